// ===== design/kwm_pkg.sv =====
`timescale 1ns / 1ps

package kwm_pkg;

  // Input command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Result kinds
  localparam logic KIND_ROW  = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Configuration register indexes
  localparam int  CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LIVE_STREAMS      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UNORDERED_STREAMS = 1'b1;

  // Field widths
  localparam int MASK_W   = 8;
  localparam int STREAM_W = 3;
  localparam int KEY_W    = 32;
  localparam int TAG_W    = 32;

  // Reset values of the configuration registers
  localparam logic [MASK_W-1:0] LIVE_RESET  = 8'hFF;
  localparam logic [MASK_W-1:0] UNORD_RESET = 8'h00;

  typedef struct packed {
    logic                cmd;
    logic [STREAM_W-1:0] stream;
    logic [KEY_W-1:0]    key;
    logic                key_null;
    logic [TAG_W-1:0]    row_tag;
  } in_req_t;

  typedef struct packed {
    logic                kind;
    logic [STREAM_W-1:0] from_stream;
    logic [KEY_W-1:0]    out_key;
    logic                out_null;
    logic [TAG_W-1:0]    out_tag;
  } out_req_t;

endpackage

// ===== design/kwm_sel.sv =====
`timescale 1ns / 1ps

module kwm_sel #(
  parameter int STREAM_COUNT = 8,
  parameter int KEY_BITS     = 32,
  localparam int IW          = $clog2(STREAM_COUNT)
) (
  input  logic [STREAM_COUNT-1:0] cand_valid,
  input  logic [STREAM_COUNT-1:0] cand_first,
  input  logic [STREAM_COUNT-1:0] cand_null,
  input  logic [KEY_BITS-1:0]     cand_key [STREAM_COUNT],
  output logic                    win_found,
  output logic [IW-1:0]           win_idx
);

  localparam int NP = 1 << IW;

  logic                lv_v   [IW+1][NP];
  logic                lv_f   [IW+1][NP];
  logic                lv_n   [IW+1][NP];
  logic [KEY_BITS-1:0] lv_k   [IW+1][NP];
  logic [IW-1:0]       lv_idx [IW+1][NP];

  // True when key a sorts strictly before key b; null is least
  function automatic logic key_less(input logic na, input logic [KEY_BITS-1:0] ka,
                                    input logic nb, input logic [KEY_BITS-1:0] kb);
    logic res;
    if (na) begin
      res = !nb;
    end else if (nb) begin
      res = 1'b0;
    end else begin
      res = (ka < kb);
    end
    return res;
  endfunction

  // Reduce pairwise; the left (lower index) side keeps ties
  always_comb begin
    logic take_r;
    for (int l = 0; l <= IW; l++) begin
      for (int j = 0; j < NP; j++) begin
        lv_v[l][j]   = 1'b0;
        lv_f[l][j]   = 1'b0;
        lv_n[l][j]   = 1'b0;
        lv_k[l][j]   = '0;
        lv_idx[l][j] = '0;
      end
    end
    for (int j = 0; j < STREAM_COUNT; j++) begin
      lv_v[0][j]   = cand_valid[j];
      lv_f[0][j]   = cand_first[j];
      lv_n[0][j]   = cand_null[j];
      lv_k[0][j]   = cand_key[j];
      lv_idx[0][j] = IW'(j);
    end
    for (int l = 0; l < IW; l++) begin
      for (int j = 0; j < NP; j++) begin
        if (j < (NP >> (l + 1))) begin
          take_r = lv_v[l][2*j+1] &&
                   (!lv_v[l][2*j] ||
                    (lv_f[l][2*j+1] && !lv_f[l][2*j]) ||
                    (!lv_f[l][2*j+1] && !lv_f[l][2*j] &&
                     key_less(lv_n[l][2*j+1], lv_k[l][2*j+1],
                              lv_n[l][2*j], lv_k[l][2*j])));
          if (take_r) begin
            lv_v[l+1][j]   = lv_v[l][2*j+1];
            lv_f[l+1][j]   = lv_f[l][2*j+1];
            lv_n[l+1][j]   = lv_n[l][2*j+1];
            lv_k[l+1][j]   = lv_k[l][2*j+1];
            lv_idx[l+1][j] = lv_idx[l][2*j+1];
          end else begin
            lv_v[l+1][j]   = lv_v[l][2*j];
            lv_f[l+1][j]   = lv_f[l][2*j];
            lv_n[l+1][j]   = lv_n[l][2*j];
            lv_k[l+1][j]   = lv_k[l][2*j];
            lv_idx[l+1][j] = lv_idx[l][2*j];
          end
        end
      end
    end
  end

  assign win_found = lv_v[IW][0];
  assign win_idx   = lv_idx[IW][0];

endmodule

// ===== design/k_way_sorted_merge_core.sv =====
`timescale 1ns / 1ps

// Sorted merge of up to eight row streams. Each request either pushes the next head row
// of a stream or ends that stream; after it is applied, the block emits at most one
// result: the winning head (unordered streams first, else the least key with null least
// and ties to the lowest stream) once every live, unended stream holds a head, or a
// single done marker when all live streams have ended and drained. One request is taken
// every clock cycle while no result is stalled; a request is registered on entry and its
// result is registered in the output register once the result slot can take it. A
// stalled result holds the request behind it. Each result comes from a single pass through
// the update logic and the pairwise winner tree over the registered heads (log2 of the
// stream count levels).
module k_way_sorted_merge_core #(
  parameter int STREAM_COUNT = 8,
  parameter int KEY_BITS     = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  kwm_pkg::in_req_t                       in_req,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output kwm_pkg::out_req_t                      out_rsp,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [kwm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [kwm_pkg::MASK_W-1:0]             cfg_data
);

  import kwm_pkg::*;

  localparam int SIW = $clog2(STREAM_COUNT);

  // Configuration registers
  logic [MASK_W-1:0] live_r;
  logic [MASK_W-1:0] unord_r;

  // Input register
  logic    item_valid_r;
  in_req_t item_r;

  // Head state
  logic [STREAM_COUNT-1:0] head_valid_r;
  logic [STREAM_COUNT-1:0] head_valid_nxt;
  logic [STREAM_COUNT-1:0] head_null_r;
  logic [KEY_BITS-1:0]     head_key_r [STREAM_COUNT];
  logic [TAG_W-1:0]        head_tag_r [STREAM_COUNT];
  logic [STREAM_COUNT-1:0] ended_r;
  logic [STREAM_COUNT-1:0] ended_nxt;
  logic                    done_sent_r;

  // Output register
  logic     out_valid_r;
  out_req_t out_r;

  logic [STREAM_COUNT-1:0] live_v;
  logic [STREAM_COUNT-1:0] first_v;
  logic [STREAM_COUNT-1:0] hit;
  logic [STREAM_COUNT-1:0] hit_push;
  logic [STREAM_COUNT-1:0] upd_valid;
  logic [STREAM_COUNT-1:0] upd_null;
  logic [KEY_BITS-1:0]     upd_key [STREAM_COUNT];
  logic [STREAM_COUNT-1:0] cand_valid;
  logic [STREAM_COUNT-1:0] clr;
  logic                    win_found;
  logic [SIW-1:0]          win_idx;
  logic                    any_head;
  logic                    all_ready;
  logic                    all_ended;
  logic                    emit_row;
  logic                    emit_done;
  logic                    advance;
  logic                    proc;
  logic                    in_take;

  // Map the 8-bit masks onto the stream slots; slots past the mask are never live
  for (genvar gi = 0; gi < STREAM_COUNT; gi++) begin : g_mask
    if (gi < MASK_W) begin : g_in
      assign live_v[gi]  = live_r[gi];
      assign first_v[gi] = unord_r[gi];
    end else begin : g_out
      assign live_v[gi]  = 1'b0;
      assign first_v[gi] = 1'b0;
    end
  end

  // Handshake: the held request advances when the result slot can take a new value
  assign advance   = !out_valid_r || !out_stall;
  assign proc      = item_valid_r && advance;
  assign in_stall  = item_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  // Apply the held request to the heads
  always_comb begin
    for (int i = 0; i < STREAM_COUNT; i++) begin
      hit[i]       = live_v[i] && (32'(item_r.stream) == i);
      hit_push[i]  = hit[i] && (item_r.cmd == CMD_PUSH) && !ended_r[i] && !head_valid_r[i];
      ended_nxt[i] = ended_r[i] || (hit[i] && (item_r.cmd == CMD_END));
      upd_valid[i] = head_valid_r[i] || hit_push[i];
      upd_null[i]  = hit_push[i] ? item_r.key_null : head_null_r[i];
      upd_key[i]   = hit_push[i] ? KEY_BITS'(item_r.key) : head_key_r[i];
    end
  end

  assign cand_valid = live_v & upd_valid;
  assign any_head   = |cand_valid;
  assign all_ready  = &(~live_v | ended_nxt | upd_valid);
  assign all_ended  = &(~live_v | ended_nxt);
  assign emit_row   = any_head && all_ready;
  assign emit_done  = !any_head && all_ended && !done_sent_r;

  kwm_sel #(
    .STREAM_COUNT (STREAM_COUNT),
    .KEY_BITS     (KEY_BITS)
  ) u_sel (
    .cand_valid (cand_valid),
    .cand_first (first_v),
    .cand_null  (upd_null),
    .cand_key   (upd_key),
    .win_found  (win_found),
    .win_idx    (win_idx)
  );

  // Drop the winning head
  always_comb begin
    for (int i = 0; i < STREAM_COUNT; i++) begin
      clr[i] = emit_row && win_found && (win_idx == SIW'(i));
    end
    head_valid_nxt = upd_valid & ~clr;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r  <= LIVE_RESET;
      unord_r <= UNORD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LIVE_STREAMS:      live_r  <= cfg_data;
        REG_UNORDERED_STREAMS: unord_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_req;
    end
  end

  // Head control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= '0;
      ended_r      <= '0;
      done_sent_r  <= 1'b0;
    end else if (proc) begin
      head_valid_r <= head_valid_nxt;
      ended_r      <= ended_nxt;
      if (emit_done) begin
        done_sent_r <= 1'b1;
      end
    end
  end

  // Head payload, written on a push
  always_ff @(posedge clk) begin
    for (int i = 0; i < STREAM_COUNT; i++) begin
      if (proc && hit_push[i]) begin
        head_null_r[i] <= item_r.key_null;
        head_key_r[i]  <= KEY_BITS'(item_r.key);
        head_tag_r[i]  <= item_r.row_tag;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (proc && (emit_row || emit_done)) || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit_row) begin
      out_r.kind        <= KIND_ROW;
      out_r.from_stream <= STREAM_W'(win_idx);
      out_r.out_key     <= upd_null[win_idx] ? '0 : KEY_W'(upd_key[win_idx]);
      out_r.out_null    <= upd_null[win_idx];
      out_r.out_tag     <= hit_push[win_idx] ? item_r.row_tag : head_tag_r[win_idx];
    end else if (proc && emit_done) begin
      out_r.kind        <= KIND_DONE;
      out_r.from_stream <= '0;
      out_r.out_key     <= '0;
      out_r.out_null    <= 1'b0;
      out_r.out_tag     <= '0;
    end
  end

endmodule

// ===== tb/tb_k_way_sorted_merge_core.sv =====
`timescale 1ns / 1ps

module tb_k_way_sorted_merge_core;
  import kwm_pkg::*;

  localparam int NSTREAM         = 8;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 148;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_CYCLES     = 80;
  localparam int IDLE_LIMIT      = 2000;
  localparam int IDLE_PCT        = 6;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    in_req_t                req;
    logic [CFG_IDX_W-1:0]   idx;
    logic [MASK_W-1:0]      val;
    bit                     typed;
    out_req_t               res;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_req_t           in_req;
  logic              out_valid;
  logic              out_stall;
  out_req_t          out_rsp;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MASK_W-1:0] cfg_data;

  // Merge state mirrored by the testbench
  logic [MASK_W-1:0]  live_mask;
  logic [MASK_W-1:0]  unord_mask;
  logic [NSTREAM-1:0] head_full;
  logic [NSTREAM-1:0] head_nul;
  logic [NSTREAM-1:0] ended;
  logic [KEY_W-1:0]   head_k [NSTREAM];
  logic [TAG_W-1:0]   head_t [NSTREAM];
  bit                 done_seen;

  out_req_t pending_results[$];
  dir_row_t directed_rows[$];
  int       fails;
  int       idle_cycles;
  bit       quiet;
  bit       hold_req;

  k_way_sorted_merge_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one request to the mirrored state and return the row or done marker it yields
  function automatic bit merge_step(input in_req_t r, output out_req_t res);
    bit all_full;
    bit any_head;
    bit all_done;
    int win;
    all_full = 1'b1;
    any_head = 1'b0;
    all_done = 1'b1;
    win      = -1;
    res      = '0;
    if (live_mask[r.stream]) begin
      if (r.cmd == CMD_END) begin
        ended[r.stream] = 1'b1;
      end else if (!ended[r.stream] && !head_full[r.stream]) begin
        head_full[r.stream] = 1'b1;
        head_nul[r.stream]  = r.key_null;
        head_k[r.stream]    = r.key;
        head_t[r.stream]    = r.row_tag;
      end
    end
    for (int i = 0; i < NSTREAM; i++) begin
      if (live_mask[i]) begin
        if (head_full[i]) any_head = 1'b1;
        if (!ended[i]) begin
          all_done = 1'b0;
          if (!head_full[i]) all_full = 1'b0;
        end
      end
    end
    if (any_head && all_full) begin
      // unordered streams go first, lowest index
      for (int i = 0; i < NSTREAM; i++) begin
        if (win < 0 && live_mask[i] && head_full[i] && unord_mask[i]) win = i;
      end
      // otherwise least key, null least, ties to the lowest index
      if (win < 0) begin
        for (int i = 0; i < NSTREAM; i++) begin
          if (live_mask[i] && head_full[i]) begin
            if (win < 0 ||
                (head_nul[i] && !head_nul[win]) ||
                (!head_nul[i] && !head_nul[win] && head_k[i] < head_k[win]))
              win = i;
          end
        end
      end
      res.kind        = KIND_ROW;
      res.from_stream = 3'(win);
      res.out_key     = head_nul[win] ? '0 : head_k[win];
      res.out_null    = head_nul[win];
      res.out_tag     = head_t[win];
      head_full[win]  = 1'b0;
      return 1'b1;
    end
    if (!any_head && all_done && !done_seen) begin
      done_seen = 1'b1;
      res.kind  = KIND_DONE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic dir_row_t mk_item(logic cmd, logic [2:0] s, logic [31:0] key,
                                       logic nul, logic [31:0] tag);
    dir_row_t row;
    row.kind        = ROW_REQ;
    row.req         = '0;
    row.idx         = '0;
    row.val         = '0;
    row.typed       = 1'b0;
    row.res         = '0;
    row.req.cmd     = cmd;
    row.req.stream  = s;
    row.req.key     = key;
    row.req.key_null = nul;
    row.req.row_tag = tag;
    return row;
  endfunction

  function automatic dir_row_t mk_chk(logic cmd, logic [2:0] s, logic [31:0] key,
                                      logic nul, logic [31:0] tag, logic kind,
                                      logic [2:0] fs, logic [31:0] okey, logic onul,
                                      logic [31:0] otag);
    dir_row_t row;
    row                 = mk_item(cmd, s, key, nul, tag);
    row.typed           = 1'b1;
    row.res.kind        = kind;
    row.res.from_stream = fs;
    row.res.out_key     = okey;
    row.res.out_null    = onul;
    row.res.out_tag     = otag;
    return row;
  endfunction

  function automatic dir_row_t mk_cfg(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] val);
    dir_row_t row;
    row.kind  = ROW_CFG;
    row.req   = '0;
    row.typed = 1'b0;
    row.res   = '0;
    row.idx   = idx;
    row.val   = val;
    return row;
  endfunction

  // Build a random request: mostly refills of open heads, the rest noise
  function automatic in_req_t gen_item(bit ending);
    in_req_t r;
    int      pool[$];
    int      roll;
    int      pick;
    r.cmd    = CMD_PUSH;
    r.stream = 3'($urandom_range(0, NSTREAM - 1));
    case ($urandom_range(0, 3))
      0: r.key = $urandom_range(0, 7);
      1: r.key = 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: r.key = $urandom();
    endcase
    r.key_null = ($urandom_range(0, 9) == 0);
    r.row_tag  = $urandom();
    roll       = $urandom_range(0, 99);
    if (ending && roll < 4) begin
      r.cmd = CMD_END;
      return r;
    end
    if (roll < 82) begin
      for (int i = 0; i < NSTREAM; i++)
        if (live_mask[i] && !ended[i] && !head_full[i]) pool = {pool, i};
    end else begin
      pick = $urandom_range(0, 2);
      for (int i = 0; i < NSTREAM; i++) begin
        if (pick == 0 && live_mask[i] && head_full[i]) pool = {pool, i};
        if (pick == 1 && !live_mask[i]) pool = {pool, i};
      end
      if (pick == 1 && $urandom_range(0, 1) == 1) r.cmd = CMD_END;
    end
    if (pool.size() != 0) r.stream = 3'(pool[$urandom_range(0, pool.size() - 1)]);
    else r.cmd = CMD_PUSH;
    return r;
  endfunction

  // Offer one request, hold it until taken, then record what it should produce
  task automatic send_req(input in_req_t r, input bit typed, input out_req_t typed_res);
    out_req_t res;
    bit       got;
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    got = merge_step(r, res);
    if (typed) pending_results = {pending_results, typed_res};
    else if (got) pending_results = {pending_results, res};
    @(negedge clk);
  endtask

  // Write a register once the block has drained
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_LIVE_STREAMS) live_mask = val;
    else unord_mask = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Compare each accepted result with the oldest pending one
  always @(posedge clk) begin : check_results
    out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0h stream %0h key %0h null %0h tag %0h",
               out_rsp.kind, out_rsp.from_stream, out_rsp.out_key, out_rsp.out_null,
               out_rsp.out_tag);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (out_rsp.kind !== want.kind) begin
          $error("kind: expected %0h, got %0h", want.kind, out_rsp.kind);
          fails++;
        end
        if (out_rsp.from_stream !== want.from_stream) begin
          $error("from_stream: expected %0h, got %0h", want.from_stream, out_rsp.from_stream);
          fails++;
        end
        if (out_rsp.out_key !== want.out_key) begin
          $error("out_key: expected %0h, got %0h", want.out_key, out_rsp.out_key);
          fails++;
        end
        if (out_rsp.out_null !== want.out_null) begin
          $error("out_null: expected %0h, got %0h", want.out_null, out_rsp.out_null);
          fails++;
        end
        if (out_rsp.out_tag !== want.out_tag) begin
          $error("out_tag: expected %0h, got %0h", want.out_tag, out_rsp.out_tag);
          fails++;
        end
      end
    end
  end

  // Abort when no handshake completes for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [MASK_W-1:0] live;
    logic [MASK_W-1:0] unord;
    bit                last;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req      = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    fails       = 0;
    idle_cycles = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    live_mask   = LIVE_RESET;
    unord_mask  = UNORD_RESET;
    head_full   = '0;
    head_nul    = '0;
    ended       = '0;
    done_seen   = 1'b0;
    for (int i = 0; i < NSTREAM; i++) begin
      head_k[i] = '0;
      head_t[i] = '0;
    end

    // Three streams: order, ties, ignored requests, draining by repeated ends, done
    directed_rows = {directed_rows, mk_cfg(REG_LIVE_STREAMS, 8'hE0)};
    directed_rows = {directed_rows, mk_item(CMD_PUSH, 5, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF)};
    directed_rows = {directed_rows, mk_item(CMD_PUSH, 6, 32'h0, 1'b0, 32'h0)};
    directed_rows = {directed_rows, mk_chk(CMD_PUSH, 7, 32'h5, 1'b1, 32'h1234,
                                           KIND_ROW, 7, 32'h0, 1'b1, 32'h1234)};
    // occupied head, stream outside the mask
    directed_rows = {directed_rows, mk_item(CMD_PUSH, 5, 32'h1, 1'b0, 32'h1)};
    directed_rows = {directed_rows, mk_item(CMD_PUSH, 3, 32'h9, 1'b0, 32'h9)};
    directed_rows = {directed_rows, mk_item(CMD_END, 2, 32'h0, 1'b0, 32'h0)};
    directed_rows = {directed_rows, mk_chk(CMD_PUSH, 7, 32'h0, 1'b0, 32'hAAAA_5555,
                                           KIND_ROW, 6, 32'h0, 1'b0, 32'h0)};
    // end streams that still hold heads, push to an ended stream
    directed_rows = {directed_rows, mk_item(CMD_END, 7, 32'h0, 1'b0, 32'h0)};
    directed_rows = {directed_rows, mk_item(CMD_PUSH, 7, 32'h3, 1'b0, 32'h3)};
    directed_rows = {directed_rows, mk_item(CMD_END, 5, 32'h0, 1'b0, 32'h0)};
    directed_rows = {directed_rows, mk_chk(CMD_END, 6, 32'h0, 1'b0, 32'h0,
                                           KIND_ROW, 7, 32'h0, 1'b0, 32'hAAAA_5555)};
    directed_rows = {directed_rows, mk_chk(CMD_END, 6, 32'h0, 1'b0, 32'h0,
                                           KIND_ROW, 5, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF)};
    directed_rows = {directed_rows, mk_chk(CMD_END, 6, 32'h0, 1'b0, 32'h0,
                                           KIND_DONE, 0, 32'h0, 1'b0, 32'h0)};
    directed_rows = {directed_rows, mk_item(CMD_END, 7, 32'h0, 1'b0, 32'h0)};
    // unordered streams beat a null key
    directed_rows = {directed_rows, mk_cfg(REG_LIVE_STREAMS, 8'h0F)};
    directed_rows = {directed_rows, mk_cfg(REG_UNORDERED_STREAMS, 8'h0A)};
    directed_rows = {directed_rows, mk_item(CMD_PUSH, 0, 32'd10, 1'b0, 32'd100)};
    directed_rows = {directed_rows, mk_item(CMD_PUSH, 1, 32'd20, 1'b0, 32'd101)};
    directed_rows = {directed_rows, mk_item(CMD_PUSH, 2, 32'd1, 1'b1, 32'd102)};
    directed_rows = {directed_rows, mk_chk(CMD_PUSH, 3, 32'd5, 1'b0, 32'd103,
                                           KIND_ROW, 1, 32'd20, 1'b0, 32'd101)};
    directed_rows = {directed_rows, mk_item(CMD_PUSH, 1, 32'h0, 1'b1, 32'd104)};
    directed_rows = {directed_rows, mk_item(CMD_PUSH, 1, 32'h7FFF_FFFF, 1'b0, 32'd105)};
    // single live stream, everything unordered
    directed_rows = {directed_rows, mk_cfg(REG_LIVE_STREAMS, 8'h01)};
    directed_rows = {directed_rows, mk_cfg(REG_UNORDERED_STREAMS, 8'hFF)};
    directed_rows = {directed_rows, mk_item(CMD_PUSH, 0, 32'h1, 1'b0, 32'h1)};
    directed_rows = {directed_rows, mk_item(CMD_PUSH, 0, 32'hFFFF_FFFF, 1'b0, 32'h5A5A_5A5A)};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed rows
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        cfg_write(directed_rows[i].idx, directed_rows[i].val);
      else
        send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    end

    // Random phases, each under its own masks; streams end only in the last one
    for (int ph = 0; ph < PHASES; ph++) begin
      last = (ph == PHASES - 1);
      if (ph == 0) begin
        live  = 8'hFF;
        unord = 8'h00;
      end else if (ph == 1) begin
        live  = 8'h01;
        unord = 8'hFF;
      end else begin
        live = last ? 8'hFF : 8'($urandom_range(1, 255));
        if ((live & 8'h1F) == 0) live = live | (8'h01 << $urandom_range(0, 4));
        case ($urandom_range(0, 3))
          0: unord = 8'h00;
          1: unord = 8'hFF;
          default: unord = 8'($urandom_range(0, 255)) & 8'($urandom_range(0, 255));
        endcase
      end
      cfg_write(REG_LIVE_STREAMS, live);
      cfg_write(REG_UNORDERED_STREAMS, unord);
      quiet = (ph == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 3 && n == 40) hold_req = 1'b1;
        send_req(gen_item(last), 1'b0, '0);
      end
    end
    quiet = 1'b0;

    // Drain and let any stray result show up
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fails == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
